>>> hdl/pdh_pkg.sv
// Shared types, widths and codes for the pulse detector with hysteresis.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pdh_pkg;

   localparam int TIME_W     = 48;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = SAMPLE_W + 1;
   localparam int IDX_W      = 12;
   localparam int LEN_W      = 13;
   localparam int LEN_CALC_W = LEN_W + 1;
   localparam int ACC_W      = 28;
   localparam int PEAK_W     = 15;
   localparam int RUN_W      = 8;
   localparam int CNT_W      = 12;
   localparam int THR_W      = 17;
   localparam int NS_W       = 10;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int PROD_W     = IDX_W + NS_W;
   localparam int DEV_W      = TIME_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = THR_W;

   // sample index and pulse count both saturate at their all-ones values
   localparam logic [IDX_W-1:0] IDX_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

   // pulse end status
   localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CUT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_GAP    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JITTER_TOL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP        = 3'd4;

   // register reset values
   localparam logic signed [THR_W-1:0] WAVE_THRESHOLD_RST = '0;
   localparam logic [RUN_W-1:0] COUNT_THRESHOLD_RST = 8'd2;
   localparam logic [NS_W-1:0]  SAMPLE_PERIOD_RST   = 10'd20;
   localparam logic [NS_W-1:0]  JITTER_TOL_RST      = 10'd10;
   localparam logic [NS_W-1:0]  MAX_GAP_RST         = 10'd80;

   typedef struct packed {
      logic signed [THR_W-1:0] wave_threshold;
      logic [RUN_W-1:0]        count_threshold;
      logic [NS_W-1:0]         sample_period_ns;
      logic [NS_W-1:0]         jitter_tolerance_ns;
      logic [NS_W-1:0]         max_gap_ns;
   } cfg_type;

   // tracker state that the grid check looks at
   typedef struct packed {
      logic              in_pulse;
      logic [IDX_W-1:0]  sample_index;
      logic [TIME_W-1:0] segment_time;
   } grid_query_type;

   // grid check verdict for the current sample
   typedef struct packed {
      logic            brk;
      logic            gap;
      logic [NS_W-1:0] gap_ns;
   } grid_type;

   typedef struct packed {
      logic [CNT_W-1:0]         wave_number;
      logic [TIME_W-1:0]        segment_time_ns;
      logic [IDX_W-1:0]         start_index;
      logic [LEN_W-1:0]         pulse_length;
      logic signed [ACC_W-1:0]  upper_total;
      logic signed [ACC_W-1:0]  lower_total;
      logic [PEAK_W-1:0]        upper_peak;
      logic [PEAK_W-1:0]        lower_peak;
      logic [STATUS_W-1:0]      end_status;
      logic [NS_W-1:0]          gap_ns;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/pdh_grid_check.sv
// Timestamp grid check: deviation of a sample from the expected grid point,
// and the break / gap decision. Depends on pdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdh_grid_check
   import pdh_pkg::*;
(
   input  wire logic [TIME_W-1:0] time_ns,
   input  wire cfg_type           cfg,
   input  wire grid_query_type    query,
   output grid_type               grid
);

   logic [PROD_W-1:0]       offset;
   logic signed [DEV_W-1:0] dev;
   logic signed [DEV_W-1:0] jit_s;
   logic signed [DEV_W-1:0] gap_lim_s;

   always_comb begin
      offset    = PROD_W'(query.sample_index) * PROD_W'(cfg.sample_period_ns);
      dev       = $signed(DEV_W'(time_ns)) - $signed(DEV_W'(query.segment_time))
                  - $signed(DEV_W'(offset));
      jit_s     = $signed(DEV_W'(cfg.jitter_tolerance_ns));
      gap_lim_s = $signed(DEV_W'(cfg.max_gap_ns));

      // first sample of a segment only sets the grid origin
      grid.brk    = (query.sample_index != '0) && ((dev > jit_s) || (dev < -jit_s));
      grid.gap    = grid.brk && query.in_pulse && (dev > 0) && (dev < gap_lim_s);
      grid.gap_ns = dev[NS_W-1:0];
   end

endmodule

`default_nettype wire

>>> hdl/pdh_tracker.sv
// Pulse tracker: hysteresis counting, per-channel sums and peaks, segment and
// pulse bookkeeping, and the result for a closing pulse. Depends on pdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdh_tracker
   import pdh_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire logic [KIND_W-1:0]          kind,
   input  wire logic [TIME_W-1:0]          time_ns,
   input  wire logic signed [SAMPLE_W-1:0] upper_sample,
   input  wire logic signed [SAMPLE_W-1:0] lower_sample,
   input  wire cfg_type                    cfg,
   input  wire grid_type                   grid,
   output grid_query_type                  query,
   output logic                            emit,
   output result_type                      result
);

   logic                    in_pulse_ff, in_pulse_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [TIME_W-1:0]       seg_ff, seg_in;
   logic [IDX_W-1:0]        start_ff, start_in;
   logic signed [ACC_W-1:0] up_acc_ff, up_acc_in;
   logic signed [ACC_W-1:0] lo_acc_ff, lo_acc_in;
   logic [PEAK_W-1:0]       up_max_ff, up_max_in;
   logic [PEAK_W-1:0]       lo_max_ff, lo_max_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    brk, ip_e, high, reach;
   logic                    norm_end, close_end;
   logic [RUN_W-1:0]        run_e, run_inc;
   logic [IDX_W-1:0]        cur, start_e;
   logic signed [ACC_W-1:0] up_acc_e, lo_acc_e, up_acc_add, lo_acc_add;
   logic [PEAK_W-1:0]       up_max_e, lo_max_e, up_max_add, lo_max_add;
   logic signed [SUM_W-1:0] wave_sum;
   logic signed [LEN_CALC_W-1:0] end_s, len_s;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]    acc,
      input logic signed [SAMPLE_W-1:0] smp
   );
      logic signed [ACC_W:0] s;
      s = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(smp));
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

   function automatic logic [PEAK_W-1:0] peak(
      input logic [PEAK_W-1:0]          cur_max,
      input logic signed [SAMPLE_W-1:0] smp
   );
      peak = (smp > $signed({1'b0, cur_max})) ? smp[PEAK_W-1:0] : cur_max;
   endfunction

   assign query.in_pulse     = in_pulse_ff;
   assign query.sample_index = idx_ff;
   assign query.segment_time = seg_ff;

   always_comb begin
      // a break closes the segment before this sample is counted
      brk      = grid.brk;
      ip_e     = in_pulse_ff && !brk;
      run_e    = brk ? '0 : run_ff;
      start_e  = brk ? '0 : start_ff;
      up_acc_e = brk ? '0 : up_acc_ff;
      lo_acc_e = brk ? '0 : lo_acc_ff;
      up_max_e = brk ? '0 : up_max_ff;
      lo_max_e = brk ? '0 : lo_max_ff;
      cur      = brk ? '0 : idx_ff;

      wave_sum   = $signed(SUM_W'(upper_sample)) + $signed(SUM_W'(lower_sample));
      high       = wave_sum >= cfg.wave_threshold;
      run_inc    = run_e + 1'b1;
      reach      = run_inc >= cfg.count_threshold;
      up_acc_add = sat_add(up_acc_e, upper_sample);
      lo_acc_add = sat_add(lo_acc_e, lower_sample);
      up_max_add = peak(up_max_e, upper_sample);
      lo_max_add = peak(lo_max_e, lower_sample);

      norm_end  = (kind == KIND_SAMPLE) && ip_e && !high && reach;
      close_end = in_pulse_ff && ((kind == KIND_END) || ((kind == KIND_SAMPLE) && brk));
      emit      = fire && (norm_end || close_end);

      if (norm_end) begin
         end_s = $signed(LEN_CALC_W'(idx_ff)) + LEN_CALC_W'(1)
                 - $signed(LEN_CALC_W'(cfg.count_threshold));
      end else if (idx_ff == '0) begin
         end_s = '0;
      end else begin
         end_s = $signed(LEN_CALC_W'(idx_ff)) - LEN_CALC_W'(1);
      end
      len_s = end_s - $signed(LEN_CALC_W'(start_ff)) + LEN_CALC_W'(1);

      count_in = (emit && (count_ff != CNT_MAX)) ? count_ff + 1'b1 : count_ff;

      result.wave_number     = count_in;
      result.segment_time_ns = seg_ff;
      result.start_index     = start_ff;
      result.pulse_length    = (len_s < LEN_CALC_W'(1)) ? LEN_W'(1) : len_s[LEN_W-1:0];
      result.upper_total     = up_acc_ff;
      result.lower_total     = lo_acc_ff;
      result.upper_peak      = up_max_ff;
      result.lower_peak      = lo_max_ff;
      if (norm_end) begin
         result.end_status = STATUS_NORMAL;
      end else if ((kind == KIND_SAMPLE) && grid.gap) begin
         result.end_status = STATUS_GAP;
      end else begin
         result.end_status = STATUS_CUT;
      end
      result.gap_ns = ((kind == KIND_SAMPLE) && grid.gap) ? grid.gap_ns : '0;

      in_pulse_in = in_pulse_ff;
      run_in      = run_ff;
      idx_in      = idx_ff;
      seg_in      = seg_ff;
      start_in    = start_ff;
      up_acc_in   = up_acc_ff;
      lo_acc_in   = lo_acc_ff;
      up_max_in   = up_max_ff;
      lo_max_in   = lo_max_ff;

      case (kind)
         KIND_SAMPLE: begin
            seg_in = ((idx_ff == '0) || brk) ? time_ns : seg_ff;
            idx_in = (cur == IDX_MAX) ? cur : cur + 1'b1;
            if (!ip_e && !high) begin
               in_pulse_in = 1'b0;
               run_in      = '0;
               start_in    = '0;
               up_acc_in   = '0;
               lo_acc_in   = '0;
               up_max_in   = '0;
               lo_max_in   = '0;
            end else if (!ip_e) begin
               in_pulse_in = reach;
               run_in      = reach ? '0 : run_inc;
               start_in    = (run_inc == RUN_W'(1)) ? cur : start_e;
               up_acc_in   = up_acc_add;
               lo_acc_in   = lo_acc_add;
               up_max_in   = up_max_add;
               lo_max_in   = lo_max_add;
            end else if (norm_end) begin
               in_pulse_in = 1'b0;
               run_in      = '0;
               start_in    = '0;
               up_acc_in   = '0;
               lo_acc_in   = '0;
               up_max_in   = '0;
               lo_max_in   = '0;
            end else begin
               // in a pulse: lows count toward the end, a high restarts the count
               run_in    = high ? '0 : run_inc;
               up_acc_in = up_acc_add;
               lo_acc_in = lo_acc_add;
               up_max_in = up_max_add;
               lo_max_in = lo_max_add;
            end
         end
         KIND_END, KIND_START: begin
            in_pulse_in = 1'b0;
            run_in      = '0;
            idx_in      = '0;
            start_in    = '0;
            up_acc_in   = '0;
            lo_acc_in   = '0;
            up_max_in   = '0;
            lo_max_in   = '0;
            if (kind == KIND_START) begin
               seg_in   = '0;
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pulse_ff <= 1'b0;
         run_ff      <= '0;
         idx_ff      <= '0;
         seg_ff      <= '0;
         start_ff    <= '0;
         up_acc_ff   <= '0;
         lo_acc_ff   <= '0;
         up_max_ff   <= '0;
         lo_max_ff   <= '0;
         count_ff    <= '0;
      end else if (fire) begin
         in_pulse_ff <= in_pulse_in;
         run_ff      <= run_in;
         idx_ff      <= idx_in;
         seg_ff      <= seg_in;
         start_ff    <= start_in;
         up_acc_ff   <= up_acc_in;
         lo_acc_ff   <= lo_acc_in;
         up_max_ff   <= up_max_in;
         lo_max_ff   <= lo_max_in;
         count_ff    <= count_in;
      end
   end

`ifndef SYNTHESIS
   // an open pulse always lies inside a segment that has samples
   a_pulse_has_index: assert property (@(posedge clock) disable iff (reset)
      in_pulse_ff |-> (idx_ff != '0))
      else $error("pulse open with zero sample index");

   // only an open pulse can produce a result
   a_emit_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      emit |-> in_pulse_ff)
      else $error("result without an open pulse");

   // start of trace clears the pulse count and closes any pulse
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (kind == KIND_START)) |=> ((count_ff == '0) && !in_pulse_ff && (idx_ff == '0)))
      else $error("start of trace left state behind");

   // a reported pulse never carries wave number zero
   a_wave_nonzero: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.wave_number != '0))
      else $error("pulse reported with wave number zero");
`endif

endmodule

`default_nettype wire

>>> hdl/pulse_detector_hysteresis_core.sv
// Input transfers enter the input register; results leave from the result register.
// Throughput: one item per cycle unless a held result waits on rsp_ready; the per-sample
// state update is one pass of logic between the input register and the result register.
// Reset: synchronous, active high; clears pulse and segment state, restores
// register defaults, and empties both pipeline registers.
// Top level of the pulse detector; depends on pdh_pkg, pdh_grid_check, pdh_tracker.
`timescale 1ns / 1ps
`default_nettype none

module pulse_detector_hysteresis_core
   import pdh_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [KIND_W-1:0]          req_kind,
   input  wire logic [TIME_W-1:0]          req_time_ns,
   input  wire logic signed [SAMPLE_W-1:0] req_upper_sample,
   input  wire logic signed [SAMPLE_W-1:0] req_lower_sample,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [CNT_W-1:0]                rsp_wave_number,
   output logic [TIME_W-1:0]               rsp_segment_time_ns,
   output logic [IDX_W-1:0]                rsp_start_index,
   output logic [LEN_W-1:0]                rsp_pulse_length,
   output logic signed [ACC_W-1:0]         rsp_upper_total,
   output logic signed [ACC_W-1:0]         rsp_lower_total,
   output logic [PEAK_W-1:0]               rsp_upper_peak,
   output logic [PEAK_W-1:0]               rsp_lower_peak,
   output logic [STATUS_W-1:0]             rsp_end_status,
   output logic [NS_W-1:0]                 rsp_gap_ns
);

   cfg_type                    cfg_ff;
   logic                       in_valid_ff;
   logic [KIND_W-1:0]          kind_ff;
   logic [TIME_W-1:0]          time_ff;
   logic signed [SAMPLE_W-1:0] upper_ff;
   logic signed [SAMPLE_W-1:0] lower_ff;
   logic                       rsp_valid_ff;
   result_type                 rsp_ff;

   logic                       fire;
   logic                       emit;
   grid_query_type             query;
   grid_type                   grid;
   result_type                 result;

   // the item in the input register is processed once the result slot is free
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_threshold      <= WAVE_THRESHOLD_RST;
         cfg_ff.count_threshold     <= COUNT_THRESHOLD_RST;
         cfg_ff.sample_period_ns    <= SAMPLE_PERIOD_RST;
         cfg_ff.jitter_tolerance_ns <= JITTER_TOL_RST;
         cfg_ff.max_gap_ns          <= MAX_GAP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVE_THRESHOLD:  cfg_ff.wave_threshold      <= $signed(csr_wdata);
            CSR_COUNT_THRESHOLD: cfg_ff.count_threshold     <= csr_wdata[RUN_W-1:0];
            CSR_SAMPLE_PERIOD:   cfg_ff.sample_period_ns    <= csr_wdata[NS_W-1:0];
            CSR_JITTER_TOL:      cfg_ff.jitter_tolerance_ns <= csr_wdata[NS_W-1:0];
            CSR_MAX_GAP:         cfg_ff.max_gap_ns          <= csr_wdata[NS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         kind_ff  <= req_kind;
         time_ff  <= req_time_ns;
         upper_ff <= req_upper_sample;
         lower_ff <= req_lower_sample;
      end
   end

   pdh_grid_check u_grid (
      .time_ns (time_ff),
      .cfg     (cfg_ff),
      .query   (query),
      .grid    (grid)
   );

   pdh_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (kind_ff),
      .time_ns      (time_ff),
      .upper_sample (upper_ff),
      .lower_sample (lower_ff),
      .cfg          (cfg_ff),
      .grid         (grid),
      .query        (query),
      .emit         (emit),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wave_number     = rsp_ff.wave_number;
   assign rsp_segment_time_ns = rsp_ff.segment_time_ns;
   assign rsp_start_index     = rsp_ff.start_index;
   assign rsp_pulse_length    = rsp_ff.pulse_length;
   assign rsp_upper_total     = rsp_ff.upper_total;
   assign rsp_lower_total     = rsp_ff.lower_total;
   assign rsp_upper_peak      = rsp_ff.upper_peak;
   assign rsp_lower_peak      = rsp_ff.lower_peak;
   assign rsp_end_status      = rsp_ff.end_status;
   assign rsp_gap_ns          = rsp_ff.gap_ns;

endmodule

`default_nettype wire
